>>> rtl/dmip_pkg.sv
package dmip_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int ROAD_W     = 3;
    localparam int FLAG_W     = 2;
    localparam int CERR_W     = 10;
    localparam int CNT_W      = 16;
    localparam int TGT_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 14;
    localparam int OVS_W      = 10;
    localparam int ERR_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_STRAIGHT_TARGET,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_DUTY_LIMIT,
        REG_OVERSPEED_ERROR
    } cfg_index_t;

    localparam logic [ROAD_W-1:0] ROAD_STRAIGHT = 3'd1;
    localparam logic [ROAD_W-1:0] ROAD_GENTLE   = 3'd2;
    localparam logic [ROAD_W-1:0] ROAD_SHARP    = 3'd3;
    localparam logic [ROAD_W-1:0] ROAD_SPECIAL  = 3'd4;

    localparam logic [FLAG_W-1:0] FLAG_NONE        = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_EXIT_GENTLE = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_EXIT_SHARP  = 2'd3;

    // error size thresholds for target selection
    localparam logic [CERR_W-1:0] SMALL_ERROR = 10'd15;
    localparam logic [CERR_W-1:0] LARGE_ERROR = 10'd26;

    localparam logic [TGT_W-1:0] TGT_150 = 8'd150;
    localparam logic [TGT_W-1:0] TGT_130 = 8'd130;
    localparam logic [TGT_W-1:0] TGT_120 = 8'd120;
    localparam logic [TGT_W-1:0] TGT_112 = 8'd112;
    localparam logic [TGT_W-1:0] TGT_110 = 8'd110;
    localparam logic [TGT_W-1:0] TGT_95  = 8'd95;
    localparam logic [TGT_W-1:0] TGT_93  = 8'd93;
    localparam logic [TGT_W-1:0] TGT_90  = 8'd90;
    localparam logic [TGT_W-1:0] TGT_85  = 8'd85;
    localparam logic [TGT_W-1:0] TGT_80  = 8'd80;
    localparam logic [TGT_W-1:0] TGT_72  = 8'd72;
    localparam logic [TGT_W-1:0] TGT_70  = 8'd70;
    localparam logic [TGT_W-1:0] TGT_60  = 8'd60;
    localparam logic [TGT_W-1:0] TGT_50  = 8'd50;

    localparam logic [TGT_W-1:0]  RST_TARGET   = 8'd100;
    localparam logic [DUTY_W-1:0] RST_SPEED    = 14'd4100;
    localparam logic [GAIN_W-1:0] RST_GAIN_P   = 16'd10240;
    localparam logic [GAIN_W-1:0] RST_GAIN_I   = 16'd1741;
    localparam logic [GAIN_W-1:0] RST_GAIN_D   = 16'd973;
    localparam logic [DUTY_W-1:0] RST_LIMIT    = 14'd8000;
    localparam logic [OVS_W-1:0]  RST_OVERSPD  = 10'd12;

    typedef struct packed {
        logic              enable;
        logic [TGT_W-1:0]  straight_target;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0] duty_limit;
        logic [OVS_W-1:0]  overspeed_error;
    } cfg_t;

    typedef struct packed {
        logic load_front;
        logic load_back;
    } wheel_ctrl_t;

endpackage

>>> rtl/dmip_target.sv
module dmip_target (
    input  logic [dmip_pkg::ROAD_W-1:0]        road,
    input  logic [dmip_pkg::FLAG_W-1:0]        flag,
    input  logic signed [dmip_pkg::CERR_W-1:0] err_c,
    input  logic signed [dmip_pkg::CERR_W-1:0] err_p1,
    input  logic signed [dmip_pkg::CERR_W-1:0] err_p2,
    input  logic signed [dmip_pkg::CERR_W-1:0] err_p3,
    input  logic [dmip_pkg::TGT_W-1:0]         straight_target,
    input  logic [dmip_pkg::TGT_W-1:0]         left_prev,
    input  logic [dmip_pkg::TGT_W-1:0]         right_prev,
    output logic [dmip_pkg::TGT_W-1:0]         left_tgt,
    output logic [dmip_pkg::TGT_W-1:0]         right_tgt,
    output logic [dmip_pkg::ROAD_W-1:0]        road_out,
    output logic [dmip_pkg::FLAG_W-1:0]        flag_out
);
    import dmip_pkg::*;

    logic [CERR_W-1:0]        a0;
    logic [CERR_W-1:0]        a1;
    logic [CERR_W-1:0]        a2;
    logic [CERR_W-1:0]        ac;
    logic signed [CERR_W:0]   a0_s;
    logic signed [CERR_W:0]   c_s;
    logic                     pos;
    logic                     small_err;
    logic                     large_err;
    logic                     trend_down;
    logic                     trend_up;

    // magnitude of -512 wraps to 512 as unsigned
    assign a0 = err_p1[CERR_W-1] ? CERR_W'(-err_p1) : CERR_W'(err_p1);
    assign a1 = err_p2[CERR_W-1] ? CERR_W'(-err_p2) : CERR_W'(err_p2);
    assign a2 = err_p3[CERR_W-1] ? CERR_W'(-err_p3) : CERR_W'(err_p3);
    assign ac = err_c[CERR_W-1]  ? CERR_W'(-err_c)  : CERR_W'(err_c);

    assign a0_s = $signed({1'b0, a0});
    assign c_s  = (CERR_W+1)'(err_c);

    assign pos       = !err_c[CERR_W-1] && (err_c != '0);
    assign small_err = ac <= SMALL_ERROR;
    assign large_err = ac >= LARGE_ERROR;

    // center error is compared with its sign
    assign trend_down = (a2 >= a1) && (a1 >= a0) && (a0_s >= c_s);
    assign trend_up   = (a2 <= a1) && (a1 <= a0) && (a0_s <= c_s);

    always_comb
    begin
        left_tgt  = left_prev;
        right_tgt = right_prev;
        road_out  = road;
        flag_out  = flag;
        case (road)
            ROAD_STRAIGHT:
            begin
                left_tgt  = straight_target;
                right_tgt = straight_target;
                if (trend_up)
                begin
                    road_out = ROAD_GENTLE;
                    flag_out = FLAG_NONE;
                end
                else if (trend_down)
                begin
                    road_out = ROAD_GENTLE;
                    flag_out = FLAG_EXIT_GENTLE;
                end
            end
            ROAD_GENTLE:
            begin
                if (flag == FLAG_EXIT_GENTLE)
                begin
                    if (pos)
                    begin
                        left_tgt  = small_err ? TGT_95 : TGT_150;
                        right_tgt = small_err ? TGT_50 : TGT_90;
                    end
                    else
                    begin
                        left_tgt  = small_err ? TGT_50 : TGT_85;
                        right_tgt = small_err ? TGT_93 : TGT_150;
                    end
                end
                else
                begin
                    left_tgt  = pos ? TGT_120 : TGT_80;
                    right_tgt = pos ? TGT_80 : TGT_120;
                end
            end
            ROAD_SHARP:
            begin
                if (flag == FLAG_EXIT_SHARP)
                begin
                    if (pos)
                    begin
                        left_tgt  = large_err ? TGT_112 : TGT_130;
                        right_tgt = large_err ? TGT_72 : TGT_85;
                    end
                    else
                    begin
                        left_tgt  = large_err ? TGT_72 : TGT_85;
                        right_tgt = large_err ? TGT_112 : TGT_130;
                    end
                end
                else
                begin
                    if (pos)
                    begin
                        left_tgt  = large_err ? TGT_110 : TGT_120;
                        right_tgt = large_err ? TGT_60 : TGT_70;
                    end
                    else
                    begin
                        left_tgt  = TGT_70;
                        right_tgt = large_err ? TGT_110 : TGT_120;
                    end
                end
            end
            ROAD_SPECIAL:
            begin
                left_tgt  = pos ? TGT_90 : TGT_50;
                right_tgt = pos ? TGT_50 : TGT_90;
            end
            default:
            begin
                left_tgt  = left_prev;
                right_tgt = right_prev;
            end
        endcase
    end

endmodule

>>> rtl/dmip_wheel.sv
module dmip_wheel #(
    parameter int GAIN_FRAC_BITS = dmip_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dmip_pkg::wheel_ctrl_t        ctrl,
    input  dmip_pkg::cfg_t               cfg,
    input  logic [dmip_pkg::TGT_W-1:0]   target,
    input  logic [dmip_pkg::CNT_W-1:0]   count,
    output logic [dmip_pkg::DUTY_W-1:0]  duty
);
    import dmip_pkg::*;

    localparam int D1_W     = ERR_W + 1;
    localparam int D2_W     = ERR_W + 3;
    localparam int PROD_P_W = GAIN_W + 1 + D1_W;
    localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_D_W = GAIN_W + 1 + D2_W;
    localparam int BASE_W   = DUTY_W + GAIN_FRAC_BITS + 1;
    localparam int SUM_W    = (BASE_W > PROD_D_W) ? BASE_W + 2 : PROD_D_W + 2;
    localparam int Q_W      = SUM_W - GAIN_FRAC_BITS;

    logic signed [ERR_W-1:0]    e0;
    logic signed [ERR_W-1:0]    e1_reg;
    logic signed [ERR_W-1:0]    e2_reg;
    logic signed [D1_W-1:0]     d1;
    logic signed [D2_W-1:0]     d2;
    logic                       over;

    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic                       over_reg;
    logic [DUTY_W-1:0]          speed_reg;

    logic signed [SUM_W-1:0]    base;
    logic signed [SUM_W-1:0]    sum;
    logic [Q_W-1:0]             quot;

    // error is exact in 18 bits for an 8-bit target and a 16-bit count
    assign e0 = $signed({{(ERR_W-TGT_W){1'b0}}, target} - {{(ERR_W-CNT_W){1'b0}}, count});

    assign d1 = D1_W'(e0) - D1_W'(e1_reg);
    assign d2 = D2_W'(e0) - (D2_W'(e1_reg) <<< 1) + D2_W'(e2_reg);

    assign over = e0 >= $signed({{(ERR_W-OVS_W){1'b0}}, cfg.overspeed_error});

    // e0 becomes the newest history entry as the products are taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg <= '0;
            e2_reg <= '0;
        end
        else if (ctrl.load_front)
        begin
            e1_reg <= e0;
            e2_reg <= e1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_front)
        begin
            prod_p_reg <= $signed({1'b0, cfg.gain_p}) * d1;
            prod_i_reg <= $signed({1'b0, cfg.gain_i}) * e0;
            prod_d_reg <= $signed({1'b0, cfg.gain_d}) * d2;
            over_reg   <= over;
        end
    end

    assign base = $signed(SUM_W'({speed_reg, {GAIN_FRAC_BITS{1'b0}}}));
    assign sum  = base + SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
    assign quot = sum[SUM_W-1:GAIN_FRAC_BITS];

    always_comb
    begin
        if (over_reg)
        begin
            duty = cfg.duty_limit;
        end
        else if (sum <= 0)
        begin
            duty = '0;
        end
        else if (quot > Q_W'(cfg.duty_limit))
        begin
            duty = cfg.duty_limit;
        end
        else
        begin
            duty = quot[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= RST_SPEED;
        end
        else if (ctrl.load_back)
        begin
            speed_reg <= duty;
        end
    end

endmodule

>>> rtl/dual_motor_incremental_pid.sv
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    road_type .. right_count
// out      source     out_valid / out_stall  left_duty, right_duty, next_road_type, next_turn_flag
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one tick per cycle sustained while out_stall is low; a result reaches the outputs through the pipeline registers
// (input register loads at the transfer, then product register, then result register)
// the speed loop closes in the last stage, history and targets in the first
// reset loads register defaults, speeds of 4100, targets of 100, zero histories
// each stage holds while the stage after it is full and stalled
module dual_motor_incremental_pid #(
    parameter int GAIN_FRAC_BITS = dmip_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dmip_pkg::ROAD_W-1:0]         road_type,
    input  logic [dmip_pkg::FLAG_W-1:0]         turn_flag,
    input  logic signed [dmip_pkg::CERR_W-1:0]  center_error,
    input  logic signed [dmip_pkg::CERR_W-1:0]  prior_error_one,
    input  logic signed [dmip_pkg::CERR_W-1:0]  prior_error_two,
    input  logic signed [dmip_pkg::CERR_W-1:0]  prior_error_three,
    input  logic [dmip_pkg::CNT_W-1:0]          left_count,
    input  logic [dmip_pkg::CNT_W-1:0]          right_count,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dmip_pkg::DUTY_W-1:0]         left_duty,
    output logic [dmip_pkg::DUTY_W-1:0]         right_duty,
    output logic [dmip_pkg::ROAD_W-1:0]         next_road_type,
    output logic [dmip_pkg::FLAG_W-1:0]         next_turn_flag,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmip_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmip_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmip_pkg::*;

    cfg_t                     cfg_reg;

    logic                     s1_valid_reg;
    logic [ROAD_W-1:0]        road_s1_reg;
    logic [FLAG_W-1:0]        flag_s1_reg;
    logic signed [CERR_W-1:0] err_c_s1_reg;
    logic signed [CERR_W-1:0] err_p1_s1_reg;
    logic signed [CERR_W-1:0] err_p2_s1_reg;
    logic signed [CERR_W-1:0] err_p3_s1_reg;
    logic [CNT_W-1:0]         lcount_s1_reg;
    logic [CNT_W-1:0]         rcount_s1_reg;

    logic                     s2_valid_reg;
    logic [ROAD_W-1:0]        road_s2_reg;
    logic [FLAG_W-1:0]        flag_s2_reg;

    logic                     out_valid_reg;
    logic [DUTY_W-1:0]        left_duty_reg;
    logic [DUTY_W-1:0]        right_duty_reg;
    logic [ROAD_W-1:0]        road_out_reg;
    logic [FLAG_W-1:0]        flag_out_reg;

    logic [TGT_W-1:0]         left_target_reg;
    logic [TGT_W-1:0]         right_target_reg;

    logic                     out_free;
    logic                     s2_free;
    logic                     s1_free;
    logic                     s1_move;
    logic                     s2_move;
    wheel_ctrl_t              wheel_ctrl;

    logic [TGT_W-1:0]         left_tgt_next;
    logic [TGT_W-1:0]         right_tgt_next;
    logic [ROAD_W-1:0]        road_next;
    logic [FLAG_W-1:0]        flag_next;
    logic [DUTY_W-1:0]        left_duty_next;
    logic [DUTY_W-1:0]        right_duty_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.straight_target <= RST_TARGET;
            cfg_reg.gain_p          <= RST_GAIN_P;
            cfg_reg.gain_i          <= RST_GAIN_I;
            cfg_reg.gain_d          <= RST_GAIN_D;
            cfg_reg.duty_limit      <= RST_LIMIT;
            cfg_reg.overspeed_error <= RST_OVERSPD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE:          cfg_reg.enable          <= cfg_data[0];
                REG_STRAIGHT_TARGET: cfg_reg.straight_target <= cfg_data[TGT_W-1:0];
                REG_GAIN_P:          cfg_reg.gain_p          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:          cfg_reg.gain_i          <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:          cfg_reg.gain_d          <= cfg_data[GAIN_W-1:0];
                REG_DUTY_LIMIT:      cfg_reg.duty_limit      <= cfg_data[DUTY_W-1:0];
                REG_OVERSPEED_ERROR: cfg_reg.overspeed_error <= cfg_data[OVS_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // stage occupancy and flow
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s2_move  = s2_valid_reg && out_free;
    assign in_stall = !s1_free;

    // state only moves while enabled
    assign wheel_ctrl.load_front = s1_move && cfg_reg.enable;
    assign wheel_ctrl.load_back  = s2_move && cfg_reg.enable;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            road_s1_reg   <= road_type;
            flag_s1_reg   <= turn_flag;
            err_c_s1_reg  <= center_error;
            err_p1_s1_reg <= prior_error_one;
            err_p2_s1_reg <= prior_error_two;
            err_p3_s1_reg <= prior_error_three;
            lcount_s1_reg <= left_count;
            rcount_s1_reg <= right_count;
        end
        if (s1_move)
        begin
            road_s2_reg <= road_next;
            flag_s2_reg <= flag_next;
        end
        if (s2_move)
        begin
            left_duty_reg  <= cfg_reg.enable ? left_duty_next : '0;
            right_duty_reg <= cfg_reg.enable ? right_duty_next : '0;
            road_out_reg   <= road_s2_reg;
            flag_out_reg   <= flag_s2_reg;
        end
    end

    dmip_target u_target (
        .road            (road_s1_reg),
        .flag            (flag_s1_reg),
        .err_c           (err_c_s1_reg),
        .err_p1          (err_p1_s1_reg),
        .err_p2          (err_p2_s1_reg),
        .err_p3          (err_p3_s1_reg),
        .straight_target (cfg_reg.straight_target),
        .left_prev       (left_target_reg),
        .right_prev      (right_target_reg),
        .left_tgt        (left_tgt_next),
        .right_tgt       (right_tgt_next),
        .road_out        (road_next),
        .flag_out        (flag_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_target_reg  <= RST_TARGET;
            right_target_reg <= RST_TARGET;
        end
        else if (wheel_ctrl.load_front)
        begin
            left_target_reg  <= left_tgt_next;
            right_target_reg <= right_tgt_next;
        end
    end

    dmip_wheel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (wheel_ctrl),
        .cfg    (cfg_reg),
        .target (left_tgt_next),
        .count  (lcount_s1_reg),
        .duty   (left_duty_next)
    );

    dmip_wheel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_wheel_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (wheel_ctrl),
        .cfg    (cfg_reg),
        .target (right_tgt_next),
        .count  (rcount_s1_reg),
        .duty   (right_duty_next)
    );

    assign out_valid      = out_valid_reg;
    assign left_duty      = left_duty_reg;
    assign right_duty     = right_duty_reg;
    assign next_road_type = road_out_reg;
    assign next_turn_flag = flag_out_reg;

endmodule
